>>> rtl/ridge_regression_sgd_engine_top_defines.svh
// Assertion macros for the ridge-regression SGD engine checker.
// No dependencies; include by bare file name.
`ifndef RIDGE_REGRESSION_SGD_ENGINE_TOP_DEFINES_SVH
`define RIDGE_REGRESSION_SGD_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define RRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rrs_pkg.sv
// Shared constants, types and helpers of the ridge-regression SGD engine.
// No dependencies.
package rrs_pkg;

    localparam int MAX_FEATURES_DEF = 16;

    localparam int OP_W       = 3;
    localparam int IDX_W      = 5;
    localparam int DATA_W     = 32;
    localparam int IN_TDATA_W = 40;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int DVD_W = 128;
    localparam int DVS_W = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
    localparam logic [OP_W-1:0] OP_FEATURE = 3'd1;
    localparam logic [OP_W-1:0] OP_TRAIN   = 3'd2;
    localparam logic [OP_W-1:0] OP_PREDICT = 3'd3;
    localparam logic [OP_W-1:0] OP_SCORE   = 3'd4;
    localparam logic [OP_W-1:0] OP_REPORT  = 3'd5;

    // Result kinds
    localparam logic KIND_PRED   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIDGE_STRENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_INTERCEPT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT  = 2'd3;

    localparam logic [15:0] LEARN_RATE_RST = 16'd655;
    localparam logic [23:0] RIDGE_RST      = 24'd65536;
    localparam logic [4:0]  FCOUNT_RST     = 5'd16;

    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [71:0] S32_MAX = 72'sd2147483647;
    localparam logic signed [71:0] S32_MIN = -72'sd2147483648;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        if (v > S32_MAX)
            return S32_MAX[31:0];
        if (v < S32_MIN)
            return S32_MIN[31:0];
        return v[31:0];
    endfunction

endpackage

>>> rtl/ridge_regression_sgd_engine_top.sv
// Top level of the ridge-regression SGD engine: sequencer, shared multiplier, stores.
// Depends on rrs_pkg and rrs_div.
//
// Usage:
//   Input beats on s_axis carry op in tuser and index/value in tdata. Results leave on
//   m_axis (kind in tuser, prediction and the r-squared report in tdata). Config
//   registers are written through cfg_valid/cfg_ready, which is always ready; write
//   only when idle.
// Sequencing (n = active feature count):
//   load weight, load feature and unused ops complete in the idle state.
//   predict, score and train run a dot-product loop over n features; train adds a weight loop.
//   The loops are set by the single registered 33x33 multiplier and the one-read
//   weight and sample memories with registered read data.
//   report: set by up to two passes of the one-bit-per-cycle divider
//   (128 steps each) plus the multiplier products for the squared target sum.
// One item is worked on at a time; s_axis_tready is low while an item runs.
// A finished result sits in the output register until taken; a later item is
// accepted meanwhile and only waits when its own result is ready to leave.
// Reset clears weights (through per-entry valid bits), bias, accumulators and
// config to their defaults; the sample buffer is left as is.
module ridge_regression_sgd_engine_top #(
    parameter int MAX_FEATURES = rrs_pkg::MAX_FEATURES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rrs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // index[4:0], value[36:5]
    input  logic [rrs_pkg::OP_W-1:0]         s_axis_tuser,   // op[2:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rrs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // prediction[31:0], rsq[63:32]
    output logic [0:0]                       m_axis_tuser,   // kind[0]
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rrs_pkg::*;

    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CW = $clog2(MAX_FEATURES + 1);

    typedef enum logic [25:0] {
        ST_IDLE = 26'h0000001,
        ST_DRD  = 26'h0000002,
        ST_DMUL = 26'h0000004,
        ST_DACC = 26'h0000008,
        ST_DFIN = 26'h0000010,
        ST_POUT = 26'h0000020,
        ST_SQ1  = 26'h0000040,
        ST_SQ2  = 26'h0000080,
        ST_SQ3  = 26'h0000100,
        ST_TRD  = 26'h0000200,
        ST_TM1  = 26'h0000400,
        ST_TM2  = 26'h0000800,
        ST_TM3  = 26'h0001000,
        ST_TM4  = 26'h0002000,
        ST_TM5  = 26'h0004000,
        ST_TM6  = 26'h0008000,
        ST_TB1  = 26'h0010000,
        ST_TB2  = 26'h0020000,
        ST_RPT  = 26'h0040000,
        ST_RQ1  = 26'h0080000,
        ST_RQ2  = 26'h0100000,
        ST_RQ3  = 26'h0200000,
        ST_RDS  = 26'h0400000,
        ST_RDV1 = 26'h0800000,
        ST_RTOT = 26'h1000000,
        ST_RDV2 = 26'h2000000
    } state_t;

    state_t state_reg, state_next;

    // Input fields
    logic [OP_W-1:0]         in_op;
    logic [IDX_W-1:0]        in_idx;
    logic signed [31:0]      in_val;
    logic                    in_acc;
    logic                    idx_in_range;
    logic                    idx_is_bias;

    assign in_op  = s_axis_tuser;
    assign in_idx = s_axis_tdata[IDX_W-1:0];
    assign in_val = s_axis_tdata[IDX_W+DATA_W-1:IDX_W];
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign idx_in_range = ({27'b0, in_idx} < 32'(MAX_FEATURES));
    assign idx_is_bias  = ({27'b0, in_idx} == 32'(MAX_FEATURES));

    // Configuration and architectural state
    logic [15:0]         lr_reg, lr_next;
    logic [23:0]         alpha_reg, alpha_next;
    logic                ui_reg, ui_next;
    logic [4:0]          fc_reg, fc_next;
    logic signed [31:0]  bias_reg, bias_next;
    logic [63:0]         ssr_reg, ssr_next;
    logic signed [63:0]  st_reg, st_next;
    logic [63:0]         sst_reg, sst_next;
    logic [31:0]         cnt_reg, cnt_next;
    logic [MAX_FEATURES-1:0] wv_reg, wv_next;

    // Working registers
    logic [OP_W-1:0]     op_reg, op_next;
    logic signed [31:0]  val_reg, val_next;
    logic [CW-1:0]       i_reg, i_next;
    logic signed [63:0]  acc_reg, acc_next;
    logic signed [31:0]  pred_reg, pred_next;
    logic signed [31:0]  err_reg, err_next;
    logic signed [31:0]  wh_reg, wh_next;
    logic signed [48:0]  g_reg, g_next;
    logic [40:0]         plo_reg, plo_next;
    logic [127:0]        sq_reg, sq_next;
    logic [63:0]         corr_reg, corr_next;
    logic signed [31:0]  rsq_reg, rsq_next;
    logic signed [65:0]  p_reg;
    logic signed [32:0]  mul_a, mul_b;

    // Output register
    logic                ov_reg, ov_next;
    logic                okind_reg, okind_next;
    logic signed [31:0]  opred_reg, opred_next;
    logic signed [31:0]  orsq_reg, orsq_next;
    logic                slot_free;

    assign slot_free = !ov_reg || m_axis_tready;

    // Active feature count, clamped
    logic [31:0]   n_wide;
    logic [CW-1:0] n_act;
    assign n_wide = ({27'b0, fc_reg} > 32'(MAX_FEATURES)) ? 32'(MAX_FEATURES) : {27'b0, fc_reg};
    assign n_act  = n_wide[CW-1:0];

    // Memories: weights and sample buffer, one write and one registered read each
    logic signed [31:0] wmem [MAX_FEATURES];
    logic signed [31:0] xmem [MAX_FEATURES];
    logic signed [31:0] w_rd_reg, x_rd_reg;
    logic               wv_rd_reg;
    logic signed [31:0] w_eff;
    logic [AW-1:0]      rd_addr;
    logic               w_we, x_we;
    logic [AW-1:0]      w_wa;
    logic signed [31:0] w_wd;

    assign rd_addr = i_reg[AW-1:0];
    assign w_eff   = wv_rd_reg ? w_rd_reg : 32'sd0;

    always_ff @(posedge clk)
    begin
        if (w_we)
            wmem[w_wa] <= w_wd;
        if (x_we)
            xmem[AW'(in_idx)] <= in_val;
        w_rd_reg <= wmem[rd_addr];
        x_rd_reg <= xmem[rd_addr];
    end

    // Divider
    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic [DVD_W-1:0]   div_q;
    div_stat_t          div_stat;

    rrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // Helper values
    logic signed [31:0]  pred_w;
    logic signed [71:0]  lrg_full;
    logic signed [71:0]  step_w;
    logic signed [41:0]  hi_prod;
    logic [64:0]         ssr_sum, sst_sum;
    logic signed [64:0]  st_sum;
    logic [63:0]         mag;
    logic [63:0]         ss_tot;
    logic signed [33:0]  one_minus;

    assign pred_w   = sat32(72'(acc_reg) + (ui_reg ? 72'(bias_reg) : 72'sd0));
    assign hi_prod  = p_reg[41:0];
    assign lrg_full = (72'(hi_prod) <<< 24) + 72'(plo_reg);
    assign step_w   = lrg_full >>> 16;
    assign ssr_sum  = {1'b0, ssr_reg} + 65'(p_reg[63:16]);
    assign sst_sum  = {1'b0, sst_reg} + 65'(p_reg[63:16]);
    assign st_sum   = 65'(st_reg) + 65'(val_reg);
    assign mag      = st_reg[63] ? (64'd0 - st_reg) : st_reg;
    assign ss_tot   = (sst_reg > corr_reg) ? (sst_reg - corr_reg) : 64'd0;
    assign one_minus = 34'(ONE_Q16) - $signed({2'b0, div_q[31:0]});

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DMUL:
            begin
                mul_a = 33'(w_eff);
                mul_b = 33'(x_rd_reg);
            end
            ST_TM1:
            begin
                mul_a = 33'(err_reg);
                mul_b = 33'(x_rd_reg);
            end
            ST_TM2:
            begin
                mul_a = 33'(alpha_reg);
                mul_b = 33'(wh_reg);
            end
            ST_TM4:
            begin
                mul_a = 33'(lr_reg);
                mul_b = 33'(g_reg[23:0]);
            end
            ST_TM5:
            begin
                mul_a = 33'(lr_reg);
                mul_b = 33'($signed(g_reg[48:24]));
            end
            ST_TB1:
            begin
                mul_a = 33'(lr_reg);
                mul_b = 33'(err_reg);
            end
            ST_SQ1:
            begin
                mul_a = 33'(err_reg);
                mul_b = 33'(err_reg);
            end
            ST_SQ2:
            begin
                mul_a = 33'(val_reg);
                mul_b = 33'(val_reg);
            end
            ST_RPT:
            begin
                mul_a = 33'(mag[31:0]);
                mul_b = 33'(mag[31:0]);
            end
            ST_RQ1:
            begin
                mul_a = 33'(mag[31:0]);
                mul_b = 33'(mag[63:32]);
            end
            ST_RQ2:
            begin
                mul_a = 33'(mag[63:32]);
                mul_b = 33'(mag[63:32]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        lr_next    = lr_reg;
        alpha_next = alpha_reg;
        ui_next    = ui_reg;
        fc_next    = fc_reg;
        bias_next  = bias_reg;
        ssr_next   = ssr_reg;
        st_next    = st_reg;
        sst_next   = sst_reg;
        cnt_next   = cnt_reg;
        wv_next    = wv_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        i_next     = i_reg;
        acc_next   = acc_reg;
        pred_next  = pred_reg;
        err_next   = err_reg;
        wh_next    = wh_reg;
        g_next     = g_reg;
        plo_next   = plo_reg;
        sq_next    = sq_reg;
        corr_next  = corr_reg;
        rsq_next   = rsq_reg;
        ov_next    = ov_reg;
        okind_next = okind_reg;
        opred_next = opred_reg;
        orsq_next  = orsq_reg;
        w_we       = 1'b0;
        w_wa       = i_reg[AW-1:0];
        w_wd       = sat32(72'(wh_reg) - step_w);
        x_we       = 1'b0;
        div_start  = 1'b0;
        div_dvd    = sq_reg;
        div_dvs    = {32'd0, cnt_reg};

        // Drop the output beat once taken
        if (ov_reg && m_axis_tready)
            ov_next = 1'b0;

        // Config writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LEARN_RATE:     lr_next    = cfg_data[15:0];
                REG_RIDGE_STRENGTH: alpha_next = cfg_data[23:0];
                REG_USE_INTERCEPT:  ui_next    = cfg_data[0];
                REG_FEATURE_COUNT:  fc_next    = cfg_data[4:0];
                default:            lr_next    = lr_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_next  = in_op;
                    val_next = in_val;
                    i_next   = '0;
                    acc_next = '0;
                    unique case (in_op)
                        OP_LOAD:
                        begin
                            if (idx_in_range)
                            begin
                                w_we = 1'b1;
                                w_wa = AW'(in_idx);
                                w_wd = in_val;
                                wv_next[AW'(in_idx)] = 1'b1;
                            end
                            else if (idx_is_bias)
                            begin
                                bias_next = in_val;
                            end
                        end
                        OP_FEATURE:
                            x_we = idx_in_range;
                        OP_TRAIN, OP_PREDICT, OP_SCORE:
                            state_next = (n_act == '0) ? ST_DFIN : ST_DRD;
                        OP_REPORT:
                            state_next = ST_RPT;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end

            // Dot product: read, multiply, accumulate
            ST_DRD:
                state_next = ST_DMUL;
            ST_DMUL:
                state_next = ST_DACC;
            ST_DACC:
            begin
                acc_next = acc_reg + 64'(p_reg >>> 16);
                i_next   = i_reg + 1'b1;
                state_next = (i_reg + 1'b1 == n_act) ? ST_DFIN : ST_DRD;
            end
            ST_DFIN:
            begin
                pred_next = pred_w;
                err_next  = sat32(72'(pred_w) - 72'(val_reg));
                i_next    = '0;
                unique case (op_reg)
                    OP_PREDICT: state_next = ST_POUT;
                    OP_SCORE:   state_next = ST_SQ1;
                    default:    state_next = (n_act == '0) ? ST_TB1 : ST_TRD;
                endcase
            end
            ST_POUT:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = KIND_PRED;
                    opred_next = pred_reg;
                    orsq_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            // Score: squared residual, then squared target
            ST_SQ1:
                state_next = ST_SQ2;
            ST_SQ2:
            begin
                ssr_next   = ssr_sum[64] ? '1 : ssr_sum[63:0];
                state_next = ST_SQ3;
            end
            ST_SQ3:
            begin
                sst_next = sst_sum[64] ? '1 : sst_sum[63:0];
                if (st_sum[64] != st_sum[63])
                    st_next = st_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                else
                    st_next = st_sum[63:0];
                if (cnt_reg != '1)
                    cnt_next = cnt_reg + 1'b1;
                state_next = ST_IDLE;
            end

            // Train: per weight, gradient then scaled step
            ST_TRD:
                state_next = ST_TM1;
            ST_TM1:
            begin
                wh_next    = w_eff;
                state_next = ST_TM2;
            end
            ST_TM2:
            begin
                g_next     = 49'(p_reg >>> 16);
                state_next = ST_TM3;
            end
            ST_TM3:
            begin
                g_next     = g_reg + 49'(p_reg >>> 16);
                state_next = ST_TM4;
            end
            ST_TM4:
                state_next = ST_TM5;
            ST_TM5:
            begin
                plo_next   = p_reg[40:0];
                state_next = ST_TM6;
            end
            ST_TM6:
            begin
                w_we = 1'b1;
                wv_next[i_reg[AW-1:0]] = 1'b1;
                i_next = i_reg + 1'b1;
                state_next = (i_reg + 1'b1 == n_act) ? ST_TB1 : ST_TRD;
            end
            ST_TB1:
                state_next = ui_reg ? ST_TB2 : ST_IDLE;
            ST_TB2:
            begin
                bias_next  = sat32(72'(bias_reg) - 72'(p_reg >>> 16));
                state_next = ST_IDLE;
            end

            // Report: square of the target sum over the count
            ST_RPT:
            begin
                corr_next  = '0;
                state_next = (cnt_reg == '0) ? ST_RTOT : ST_RQ1;
            end
            ST_RQ1:
            begin
                sq_next    = 128'(p_reg[63:0]);
                state_next = ST_RQ2;
            end
            ST_RQ2:
            begin
                sq_next    = sq_reg + (128'(p_reg[63:0]) << 33);
                state_next = ST_RQ3;
            end
            ST_RQ3:
            begin
                sq_next    = sq_reg + (128'(p_reg[63:0]) << 64);
                state_next = ST_RDS;
            end
            ST_RDS:
            begin
                div_start  = 1'b1;
                state_next = ST_RDV1;
            end
            ST_RDV1:
            begin
                if (div_stat.done)
                begin
                    corr_next  = (div_q[127:80] != '0) ? '1 : div_q[79:16];
                    state_next = ST_RTOT;
                end
            end
            ST_RTOT:
            begin
                if (ss_tot == '0)
                begin
                    rsq_next   = (ssr_reg == '0) ? ONE_Q16 : 32'sd0;
                    g_next     = '0;
                    state_next = ST_RDV2;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_dvd    = {48'd0, ssr_reg, 16'd0};
                    div_dvs    = ss_tot;
                    g_next     = 49'd1;
                    state_next = ST_RDV2;
                end
            end
            ST_RDV2:
            begin
                // Zero variance skips the divide; otherwise wait for the ratio
                if (g_reg == '0 || div_stat.done)
                begin
                    if (g_reg != '0)
                    begin
                        if (div_q[127:32] != '0)
                            rsq_next = S32_MIN[31:0];
                        else
                            rsq_next = sat32(72'(one_minus));
                    end
                    g_next = '0;
                    if (slot_free && g_reg == '0)
                    begin
                        ov_next    = 1'b1;
                        okind_next = KIND_REPORT;
                        opred_next = '0;
                        orsq_next  = rsq_reg;
                        ssr_next   = '0;
                        st_next    = '0;
                        sst_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lr_reg    <= LEARN_RATE_RST;
            alpha_reg <= RIDGE_RST;
            ui_reg    <= 1'b1;
            fc_reg    <= FCOUNT_RST;
            bias_reg  <= '0;
            ssr_reg   <= '0;
            st_reg    <= '0;
            sst_reg   <= '0;
            cnt_reg   <= '0;
            wv_reg    <= '0;
            ov_reg    <= 1'b0;
            wv_rd_reg <= 1'b0;
            g_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lr_reg    <= lr_next;
            alpha_reg <= alpha_next;
            ui_reg    <= ui_next;
            fc_reg    <= fc_next;
            bias_reg  <= bias_next;
            ssr_reg   <= ssr_next;
            st_reg    <= st_next;
            sst_reg   <= sst_next;
            cnt_reg   <= cnt_next;
            wv_reg    <= wv_next;
            ov_reg    <= ov_next;
            wv_rd_reg <= wv_reg[rd_addr];
            g_reg     <= g_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        val_reg   <= val_next;
        i_reg     <= i_next;
        acc_reg   <= acc_next;
        pred_reg  <= pred_next;
        err_reg   <= err_next;
        wh_reg    <= wh_next;
        plo_reg   <= plo_next;
        sq_reg    <= sq_next;
        corr_reg  <= corr_next;
        rsq_reg   <= rsq_next;
        okind_reg <= okind_next;
        opred_reg <= opred_next;
        orsq_reg  <= orsq_next;
        p_reg     <= mul_a * mul_b;
    end

    assign s_axis_tready   = (state_reg == ST_IDLE) && !div_stat.busy;
    assign cfg_ready       = 1'b1;
    assign m_axis_tvalid   = ov_reg;
    assign m_axis_tuser[0] = okind_reg;
    assign m_axis_tdata    = {orsq_reg, opred_reg};

endmodule

>>> rtl/rrs_div.sv
// Restoring divider, one quotient bit per cycle, 128-bit dividend by 64-bit divisor.
// Depends on rrs_pkg.
module rrs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rrs_pkg::DVD_W-1:0]   dividend,
    input  logic [rrs_pkg::DVS_W-1:0]   divisor,
    output logic [rrs_pkg::DVD_W-1:0]   quotient,
    output rrs_pkg::div_stat_t          stat
);
    import rrs_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // Shift in one dividend bit and try the subtract
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Hold control under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> rtl/rrs_chk.sv
// Port-level checker for the ridge-regression SGD engine, bound to the top level.
// Depends on rrs_pkg and ridge_regression_sgd_engine_top_defines.svh.
`include "ridge_regression_sgd_engine_top_defines.svh"

module rrs_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [rrs_pkg::OP_W-1:0]         s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rrs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [0:0]                       m_axis_tuser
);
    import rrs_pkg::*;

    logic in_beat;
    logic long_op;
    logic short_op;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign long_op  = (s_axis_tuser == OP_TRAIN) || (s_axis_tuser == OP_PREDICT) ||
                      (s_axis_tuser == OP_SCORE) || (s_axis_tuser == OP_REPORT);
    assign short_op = !long_op;

    // Hold a stalled result beat
    `RRS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

    // Multi-cycle ops drop ready right after acceptance
    `RRS_ASSERT_NXT(a_busy_after_long, in_beat && long_op, !s_axis_tready, "ready stayed high after a multi-cycle op")

    // Loads and unused ops leave ready high right after acceptance
    `RRS_ASSERT_NXT(a_ready_after_short, in_beat && short_op, s_axis_tready, "ready dropped after a one-cycle op")

    // The field that a result kind does not use is zero
    `RRS_ASSERT_IMP(a_kind_fields, m_axis_tvalid, (m_axis_tuser[0] == KIND_PRED) ? (m_axis_tdata[63:32] == '0) : (m_axis_tdata[31:0] == '0), "unused result field not zero")

endmodule

bind ridge_regression_sgd_engine_top rrs_chk u_rrs_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/ridge_regression_sgd_engine_checker.sv
// Checker for the ridge-regression SGD engine: watches the input, result and
// config channels, predicts each result and compares it field by field.
// Depends on rrs_pkg.
module ridge_regression_sgd_engine_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [rrs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // index[4:0], value[36:5]
    input  logic [rrs_pkg::OP_W-1:0]        s_axis_tuser,   // op[2:0]
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [rrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // prediction[31:0], rsq[63:32]
    input  logic [0:0]                      m_axis_tuser,   // kind[0]
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rrs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import rrs_pkg::*;

    localparam int NF = MAX_FEATURES_DEF;

    typedef struct {
        logic              kind;
        logic signed [31:0] prediction;
        logic signed [31:0] rsq;
    } engine_result_t;

    // Model copy of configuration and state
    logic [15:0]       lr;
    logic [23:0]       alpha;
    logic              intercept_on;
    logic [4:0]        feat_count;
    int                weight_mem [NF];
    int                bias;
    int                sample_mem [NF];
    logic [63:0]       sum_sq_res;
    logic signed [63:0] sum_tgt;
    logic [63:0]       sum_sq_tgt;
    logic [31:0]       n_scored;

    engine_result_t result_queue [$];

    function automatic int clamp_q16(input logic signed [95:0] v);
        if (v > 96'sd2147483647)
            return 32'sh7fffffff;
        if (v < -96'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic int active_n();
        return (feat_count > NF) ? NF : int'(feat_count);
    endfunction

    function automatic int dot_plus_bias();
        longint acc;
        acc = 0;
        for (int i = 0; i < active_n(); i++)
            acc += (longint'(weight_mem[i]) * longint'(sample_mem[i])) >>> 16;
        if (intercept_on)
            acc += bias;
        return clamp_q16(acc);
    endfunction

    function automatic logic [63:0] add_usat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic int rsq_now();
        logic [63:0]  mag, corr, ss_tot;
        logic [127:0] quo, ratio;
        logic signed [95:0] diff;
        corr = 0;
        if (n_scored != 0) begin
            mag = sum_tgt[63] ? (64'd0 - sum_tgt) : sum_tgt;
            quo = ({64'd0, mag} * {64'd0, mag}) / n_scored;
            quo = quo >> 16;
            corr = (|quo[127:64]) ? '1 : quo[63:0];
        end
        ss_tot = (sum_sq_tgt > corr) ? sum_sq_tgt - corr : 64'd0;
        if (ss_tot == 0)
            return (sum_sq_res == 0) ? 65536 : 0;
        if (sum_sq_res / ss_tot >= 64'd65536)
            return 32'sh80000000;
        ratio = {48'd0, sum_sq_res, 16'd0} / {64'd0, ss_tot};
        diff = 96'sd65536 - $signed({1'b0, ratio[94:0]});
        return clamp_q16(diff);
    endfunction

    // Advance the model by one accepted item, queue any result it causes
    task automatic apply_item(input logic [2:0] op, input logic [4:0] idx, input int val);
        int          err, old_w [NF];
        longint      g, sq;
        logic signed [95:0] step;
        logic signed [64:0] ssum;
        engine_result_t r;
        case (op)
            OP_LOAD:
                if (idx < NF)
                    weight_mem[idx] = val;
                else if (idx == NF)
                    bias = val;
            OP_FEATURE:
                if (idx < NF)
                    sample_mem[idx] = val;
            OP_TRAIN:
            begin
                err = clamp_q16(longint'(dot_plus_bias()) - longint'(val));
                old_w = weight_mem;
                for (int i = 0; i < active_n(); i++) begin
                    g = ((longint'(err) * longint'(sample_mem[i])) >>> 16)
                      + ((longint'(alpha) * longint'(old_w[i])) >>> 16);
                    step = (96'(g) * $signed({80'd0, lr})) >>> 16;
                    weight_mem[i] = clamp_q16(96'(old_w[i]) - step);
                end
                if (intercept_on)
                    bias = clamp_q16(longint'(bias)
                                     - ((longint'(lr) * longint'(err)) >>> 16));
            end
            OP_PREDICT:
            begin
                r.kind = KIND_PRED;
                r.prediction = dot_plus_bias();
                r.rsq = 0;
                result_queue.push_back(r);
            end
            OP_SCORE:
            begin
                err = clamp_q16(longint'(dot_plus_bias()) - longint'(val));
                sq = longint'(err) * longint'(err);
                sum_sq_res = add_usat(sum_sq_res, 64'(sq) >> 16);
                ssum = 65'(sum_tgt) + 65'(val);
                if (ssum > 65'sh0_7fff_ffff_ffff_ffff)
                    sum_tgt = 64'sh7fff_ffff_ffff_ffff;
                else if (ssum < -65'sh0_8000_0000_0000_0000)
                    sum_tgt = 64'sh8000_0000_0000_0000;
                else
                    sum_tgt = ssum[63:0];
                sq = longint'(val) * longint'(val);
                sum_sq_tgt = add_usat(sum_sq_tgt, 64'(sq) >> 16);
                if (n_scored != '1)
                    n_scored++;
            end
            OP_REPORT:
            begin
                r.kind = KIND_REPORT;
                r.prediction = 0;
                r.rsq = rsq_now();
                result_queue.push_back(r);
                sum_sq_res = 0;
                sum_tgt = 0;
                sum_sq_tgt = 0;
                n_scored = 0;
            end
            default: ;
        endcase
    endtask

    // Track the channels and compare each result beat with the oldest expectation
    always @(posedge clk or negedge rst_n) begin
        engine_result_t exp_r;
        if (!rst_n) begin
            lr = LEARN_RATE_RST;
            alpha = RIDGE_RST;
            intercept_on = 1'b1;
            feat_count = FCOUNT_RST;
            for (int i = 0; i < NF; i++) begin
                weight_mem[i] = 0;
                sample_mem[i] = 0;
            end
            bias = 0;
            sum_sq_res = 0;
            sum_tgt = 0;
            sum_sq_tgt = 0;
            n_scored = 0;
            result_queue.delete();
            fail_count = 0;
            pending = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LEARN_RATE:     lr = cfg_data[15:0];
                    REG_RIDGE_STRENGTH: alpha = cfg_data[23:0];
                    REG_USE_INTERCEPT:  intercept_on = cfg_data[0];
                    REG_FEATURE_COUNT:  feat_count = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_queue.size() == 0) begin
                    $error("result beat with nothing expected: tuser=%0d tdata=%h",
                           m_axis_tuser, m_axis_tdata);
                    fail_count++;
                end
                else begin
                    exp_r = result_queue.pop_front();
                    if (m_axis_tuser[0] !== exp_r.kind) begin
                        $error("kind: expected %0d, got %0d", exp_r.kind, m_axis_tuser[0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[31:0] !== exp_r.prediction) begin
                        $error("prediction: expected %0d, got %0d", exp_r.prediction,
                               $signed(m_axis_tdata[31:0]));
                        fail_count++;
                    end
                    if (m_axis_tdata[63:32] !== exp_r.rsq) begin
                        $error("rsq: expected %0d, got %0d", exp_r.rsq,
                               $signed(m_axis_tdata[63:32]));
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_item(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[36:5]);
            pending = result_queue.size();
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the ridge-regression SGD engine testbench: clock, reset, stimulus and verdict.
// Depends on rrs_pkg, ridge_regression_sgd_engine_top and ridge_regression_sgd_engine_checker.
module testbench;
    import rrs_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int NF          = MAX_FEATURES_DEF;
    localparam int DRAIN_WAIT  = 400;
    localparam int PHASE_ITEMS = 280;
    localparam int PHASES      = 6;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]        s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     pending;
    logic                   calm;
    int                     n_now;
    int                     stall_left;

    ridge_regression_sgd_engine_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ridge_regression_sgd_engine_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hold off the result side in random bursts, none once calm
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end
        else if (calm) begin
            m_axis_tready <= 1'b1;
        end
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(1, 17) - 1;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Send one beat, sometimes with a random gap ahead of it
    task automatic send_item(input logic [2:0] op, input logic [4:0] idx, input int val);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {3'b0, val, idx};
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
    endtask

    // Present one register write; the caller drops valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
    endtask

    // Drop valid, wait for every result and let trailing work finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic int pick_value(input int wide_pct);
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            default:
                if ($urandom_range(0, 99) < wide_pct)
                    return $urandom;
                else
                    return $signed($urandom_range(0, 262143)) - 131072;
        endcase
    endfunction

    task automatic run_random(input int count);
        int sent, k, j;
        sent = 0;
        while (sent < count) begin
            k = $urandom_range(0, 9);
            if (k <= 4) begin
                // well-formed sample, then train, score or predict
                j = (n_now == 0) ? 0 : $urandom_range(1, n_now);
                for (int i = 0; i < j; i++) begin
                    send_item(OP_FEATURE, 5'($urandom_range(0, n_now - 1)), pick_value(15));
                    sent++;
                end
                case ($urandom_range(0, 3))
                    0, 1: send_item(OP_TRAIN, 5'($urandom_range(0, 31)), pick_value(15));
                    2: send_item(OP_SCORE, 5'($urandom_range(0, 31)), pick_value(15));
                    default: send_item(OP_PREDICT, 5'($urandom_range(0, 31)), $urandom);
                endcase
                sent++;
            end
            else if (k == 5) begin
                send_item(OP_PREDICT, 5'($urandom_range(0, 31)), $urandom);
                sent++;
            end
            else if (k == 6) begin
                send_item(OP_REPORT, 5'($urandom_range(0, 31)), $urandom);
                sent++;
            end
            else if (k == 7) begin
                send_item(OP_LOAD, 5'($urandom_range(0, 31)), pick_value(30));
                sent++;
            end
            else if (k == 8) begin
                // noise: any op, any index
                send_item(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)), $urandom);
                sent++;
            end
            else begin
                j = $urandom_range(2, 6);
                for (int i = 0; i < j; i++)
                    send_item(OP_TRAIN, 5'd0, pick_value(10));
                sent += j;
            end
        end
    endtask

    initial begin
        logic [15:0] lr_v;
        logic [23:0] alpha_v;
        logic        icpt_v;
        logic [4:0]  fc_v;
        rst_n = 1'b0;
        calm = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        n_now = NF;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    lr_v = 16'd655; alpha_v = 24'd65536; icpt_v = 1'b1; fc_v = 5'd16;
                end
                1: begin lr_v = 16'd0; alpha_v = 24'd0; icpt_v = 1'b0; fc_v = 5'd0; end
                2: begin
                    lr_v = 16'hffff; alpha_v = 24'hffffff; icpt_v = 1'b1; fc_v = 5'd16;
                end
                3: begin
                    lr_v = 16'($urandom); alpha_v = 24'($urandom);
                    icpt_v = 1'($urandom); fc_v = 5'($urandom_range(17, 31));
                end
                default: begin
                    lr_v = 16'($urandom_range(0, 4000));
                    alpha_v = 24'($urandom_range(0, 131072));
                    icpt_v = 1'($urandom); fc_v = 5'($urandom_range(1, 16));
                end
            endcase
            calm = (p == PHASES - 1);
            write_reg(REG_LEARN_RATE, 32'(lr_v));
            write_reg(REG_RIDGE_STRENGTH, 32'(alpha_v));
            write_reg(REG_USE_INTERCEPT, 32'(icpt_v));
            write_reg(REG_FEATURE_COUNT, 32'(fc_v));
            cfg_valid <= 1'b0;
            n_now = (int'(fc_v) > NF) ? NF : int'(fc_v);

            if (p == 0) begin
                // fill every sample entry, extremes first
                send_item(OP_FEATURE, 5'd0, 32'sh7fffffff);
                send_item(OP_FEATURE, 5'd1, 32'sh80000000);
                send_item(OP_FEATURE, 5'd2, -1);
                for (int i = 3; i < NF; i++)
                    send_item(OP_FEATURE, 5'(i), pick_value(20));
                send_item(OP_PREDICT, 5'd0, 0);
                send_item(OP_REPORT, 5'd0, 0);          // nothing scored yet
                send_item(OP_LOAD, 5'd0, 32'sh7fffffff);
                send_item(OP_LOAD, 5'd1, 32'sh80000000);
                send_item(OP_LOAD, 5'(NF), 65536);      // bias
                send_item(OP_LOAD, 5'd31, 12345);       // out of range, ignored
                send_item(OP_FEATURE, 5'd31, -7);       // out of range, ignored
                send_item(OP_SPARE_LO, 5'd5, -1);
                send_item(OP_SPARE_HI, 5'd31, 32'sh80000000);
                send_item(OP_PREDICT, 5'd31, -1);
                send_item(OP_TRAIN, 5'd0, 32'sh80000000);
                send_item(OP_SCORE, 5'd0, 32'sh7fffffff);
                send_item(OP_SCORE, 5'd0, -1);
                send_item(OP_REPORT, 5'd0, 0);
                send_item(OP_SCORE, 5'd0, 0);
                send_item(OP_REPORT, 5'd0, 0);
            end
            run_random(PHASE_ITEMS);
            send_item(OP_REPORT, 5'd0, 0);
            drain();
        end

        if (fail_count == 0)
            $display("ridge_regression_sgd_engine_top: match");
        else
            $display("ridge_regression_sgd_engine_top: mismatch");
        $finish;
    end

    // Give up after a generous fixed time
    initial begin
        #40_000_000;
        $display("ridge_regression_sgd_engine_top: mismatch");
        $finish;
    end

endmodule
